// ----- src/gww_pkg.sv -----
package gww_pkg;

  localparam int CharW  = 8;
  localparam int KindW  = 2;
  localparam int CfgW   = 6;
  localparam int FillW  = 6;

  localparam int WidthReset = 39;
  localparam int WidthMin   = 2;
  localparam int WidthMax   = 62;

  localparam logic [CharW-1:0] ChSpace   = 8'd32;
  localparam logic [CharW-1:0] ChNewline = 8'd10;
  localparam logic [CharW-1:0] ChTab     = 8'd9;
  localparam logic [CharW-1:0] ChCr      = 8'd13;

  localparam logic [KindW-1:0] KindChar  = 2'd0;
  localparam logic [KindW-1:0] KindOk    = 2'd1;
  localparam logic [KindW-1:0] KindEmpty = 2'd2;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             end_of_text;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic [KindW-1:0] out_kind;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic accept;
    logic store_char;
    logic fill_update;
    logic load_sep;
    logic load_char;
    logic load_mark;
    logic clear_word;
    logic clear_all;
    logic rd_advance;
    logic rd_hold;
  } cmd_t;

  typedef struct packed {
    logic wl_zero;
    logic need_sep;
    logic full;
    logic in_eot;
    logic in_ws;
    logic out_free;
    logic last_char;
    logic eot_pending;
  } status_t;

endpackage

// ----- src/greedy_word_wrapper.sv -----
// Channel  Direction  Signals                          Transfer when
// in       input      in_valid_i, in_ready_o, in_i     in_valid_i && in_ready_o
// out      output     out_valid_o, out_ready_i, out_o  out_valid_o && out_ready_i
// cfg      input      cfg_we_i, cfg_wdata_i            cfg_we_i
//
// A byte is taken per transfer on the in channel. A finished word is then written out
// as a separator decision followed by its characters one by one, paced by the single
// read port of the word buffer and the one-entry output register; end of text adds a
// marker after the word.
// Reset clears control state and sets the width to 39; the word buffer is not cleared.
// A stall on out_ready_i holds the controller; input is taken only between words.
module greedy_word_wrapper #(
  parameter int WORD_DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gww_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  gww_pkg::in_t              in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output gww_pkg::out_t             out_o
);
  import gww_pkg::*;

  cmd_t    cmd;
  status_t status;

  gww_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gww_dpath #(
    .WORD_DEPTH (WORD_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  // an end marker always closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.out_kind != KindChar |-> out_o.last_of_run)
    else $error("end marker without last_of_run");

  // separators never close a run, since whitespace never enters a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.out_kind == KindChar &&
    (out_o.out_char == ChSpace || out_o.out_char == ChNewline) |-> !out_o.last_of_run)
    else $error("separator marked as last of run");

  // end of text always produces a marker, so input must close after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.end_of_text |=> !in_ready_o)
    else $error("input reopened right after end of text");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.out_kind == KindChar || out_o.out_kind == KindOk ||
                     out_o.out_kind == KindEmpty))
    else $error("undefined result kind");

endmodule

// ----- src/gww_ctrl.sv -----
module gww_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gww_pkg::status_t  status_i,
  output gww_pkg::cmd_t     cmd_o
);
  import gww_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StStart = 4'b0010,
    StChars = 4'b0100,
    StMark  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.in_eot || status_i.in_ws) begin
            state_d = StStart;
          end else begin
            cmd_o.store_char = 1'b1;
            if (status_i.full) begin
              state_d = StStart;
            end
          end
        end
      end
      StStart: begin
        if (status_i.wl_zero) begin
          state_d = status_i.eot_pending ? StMark : StIdle;
        end else if (status_i.need_sep) begin
          if (status_i.out_free) begin
            cmd_o.load_sep    = 1'b1;
            cmd_o.fill_update = 1'b1;
            state_d           = StChars;
          end
        end else begin
          // first word on the output: no separator
          cmd_o.fill_update = 1'b1;
          state_d           = StChars;
        end
      end
      StChars: begin
        if (status_i.out_free) begin
          cmd_o.load_char  = 1'b1;
          cmd_o.rd_advance = 1'b1;
          if (status_i.last_char) begin
            cmd_o.clear_word = 1'b1;
            state_d = status_i.eot_pending ? StMark : StIdle;
          end
        end else begin
          cmd_o.rd_hold = 1'b1;
        end
      end
      StMark: begin
        if (status_i.out_free) begin
          cmd_o.load_mark = 1'b1;
          cmd_o.clear_all = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/gww_dpath.sv -----
module gww_dpath #(
  parameter int WORD_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gww_pkg::CfgW-1:0]   cfg_wdata_i,
  input  gww_pkg::in_t               in_i,
  input  logic                       out_ready_i,
  input  gww_pkg::cmd_t              cmd_i,
  output gww_pkg::status_t           status_o,
  output logic                       out_valid_o,
  output gww_pkg::out_t              out_o
);
  import gww_pkg::*;

  localparam int AW = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
  localparam int LW = $clog2(WORD_DEPTH + 1);

  logic [CfgW-1:0]  width_q;
  logic [LW-1:0]    wl_q;
  logic [FillW-1:0] lf_q;
  logic             eot_q;
  logic [LW-1:0]    rd_idx_q, rd_idx_d;
  logic [CharW-1:0] rd_data_q;
  logic [CharW-1:0] mem [WORD_DEPTH];
  logic             out_valid_q;
  out_t             out_q;

  logic [7:0] width_eff;
  logic [7:0] wl_ext;
  logic [7:0] lf_ext;
  logic [7:0] fill_sum;
  logic [7:0] lf_new;
  logic       fits;
  logic       out_free;
  logic       last_char;

  // clamp the configured width to the legal range and the buffer depth
  always_comb begin
    width_eff = 8'(width_q);
    if (width_eff < 8'(WidthMin)) begin
      width_eff = 8'(WidthMin);
    end
    if (width_eff > 8'(WidthMax)) begin
      width_eff = 8'(WidthMax);
    end
    if (width_eff > 8'(WORD_DEPTH)) begin
      width_eff = 8'(WORD_DEPTH);
    end
  end

  assign wl_ext    = 8'(wl_q);
  assign lf_ext    = 8'(lf_q);
  assign fill_sum  = lf_ext + wl_ext + 8'd1;
  assign fits      = (fill_sum <= width_eff);
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_char = ((8'(rd_idx_q) + 8'd1) == wl_ext);

  always_comb begin
    if (lf_q != '0 && fits) begin
      lf_new = fill_sum;
    end else begin
      lf_new = wl_ext;
    end
  end

  always_comb begin
    status_o.wl_zero     = (wl_q == '0);
    status_o.need_sep    = (lf_q != '0);
    status_o.full        = ((wl_ext + 8'd1) >= width_eff);
    status_o.in_eot      = in_i.end_of_text;
    status_o.in_ws       = (in_i.in_char >= ChTab && in_i.in_char <= ChCr) ||
                           (in_i.in_char == ChSpace);
    status_o.out_free    = out_free;
    status_o.last_char   = last_char;
    status_o.eot_pending = eot_q;
  end

  // advance the read index on each loaded character, hold it while the output stalls, else restart at zero
  always_comb begin
    if (cmd_i.rd_advance) begin
      rd_idx_d = rd_idx_q + LW'(1);
    end else if (cmd_i.rd_hold) begin
      rd_idx_d = rd_idx_q;
    end else begin
      rd_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CfgW'(WidthReset);
      wl_q        <= '0;
      lf_q        <= '0;
      eot_q       <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_word || cmd_i.clear_all) begin
        wl_q <= '0;
      end else if (cmd_i.store_char) begin
        wl_q <= wl_q + LW'(1);
      end
      if (cmd_i.clear_all) begin
        lf_q <= '0;
      end else if (cmd_i.fill_update) begin
        lf_q <= lf_new[FillW-1:0];
      end
      if (cmd_i.accept) begin
        eot_q <= in_i.end_of_text;
      end
      rd_idx_q <= rd_idx_d;
      if (cmd_i.load_sep || cmd_i.load_char || cmd_i.load_mark) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_char) begin
      mem[wl_q[AW-1:0]] <= in_i.in_char;
    end
    rd_data_q <= mem[rd_idx_d[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sep) begin
      out_q.out_char    <= fits ? ChSpace : ChNewline;
      out_q.out_kind    <= KindChar;
      out_q.last_of_run <= 1'b0;
    end else if (cmd_i.load_char) begin
      out_q.out_char    <= rd_data_q;
      out_q.out_kind    <= KindChar;
      out_q.last_of_run <= last_char && !eot_q;
    end else if (cmd_i.load_mark) begin
      out_q.out_char    <= '0;
      out_q.out_kind    <= (lf_q == '0) ? KindEmpty : KindOk;
      out_q.last_of_run <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
